// ===== hdl/bopc_pkg.sv =====
package bopc_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int COUNT_W     = 25;
   localparam int SUM_W       = 56;
   localparam int VALUE_W     = 31;
   localparam int COL_W       = 14;
   localparam int ROW_W       = 24;
   localparam int BYTES_W     = 27;
   localparam int ROW_WIDTH_W = 15;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 25;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   localparam logic [7:0]             ESCAPE_BYTE    = 8'h80;
   localparam logic [7:0]             ZERO_BYTE      = 8'h00;
   localparam logic [SAMPLE_W-1:0]    ONE_BYTE_LIMIT = 32'd127;
   localparam logic [SAMPLE_W-1:0]    TWO_BYTE_LIMIT = 32'd32767;
   localparam logic [ROW_WIDTH_W-1:0] MAX_ROW_WIDTH  = 15'd16384;

   localparam logic [1:0] SAMPLE_8  = 2'd0;
   localparam logic [1:0] SAMPLE_16 = 2'd1;
   localparam logic [1:0] SAMPLE_32 = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_BITS,
      CSR_SIGNED,
      CSR_STATS_OFF,
      CSR_ROW_WIDTH,
      CSR_PIXEL_COUNT
   } csr_index_type;

   typedef enum logic [1:0] {
      LEN_ONE,
      LEN_THREE,
      LEN_SEVEN
   } len_type;

   typedef struct packed {
      logic               too_random;
      logic [COUNT_W-1:0] overflow_count;
      logic [COUNT_W-1:0] underflow_count;
      logic [COUNT_W-1:0] valid_count;
      logic [SUM_W-1:0]   value_sum;
      logic [VALUE_W-1:0] max_value;
      logic [COL_W-1:0]   max_col;
      logic [ROW_W-1:0]   max_row;
      logic [VALUE_W-1:0] min_value;
   } stats_type;

   // Statistics of an empty image: everything zero, the minimum at the largest value.
   localparam stats_type STATS_CLEAR = '{min_value: {VALUE_W{1'b1}}, default: '0};

   typedef struct packed {
      logic [SAMPLE_W-1:0] diff;
      len_type             len;
      logic                image_start;
      stats_type           stats;
   } record_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [COUNT_W-1:0] sat_inc_count(input logic [COUNT_W-1:0] x);
      return (x == '1) ? x : x + 1'b1;
   endfunction

endpackage

// ===== hdl/bopc_if.sv =====
interface bopc_req_if;
   import bopc_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] raw_sample;
   logic                image_start;
   modport source (output valid, output raw_sample, output image_start, input ready);
   modport sink (input valid, input raw_sample, input image_start, output ready);
endinterface

interface bopc_rsp_if;
   import bopc_pkg::*;
   logic               valid;
   logic               ready;
   logic [7:0]         out_byte;
   logic               pixel_done;
   logic               too_random;
   logic [COUNT_W-1:0] overflow_count;
   logic [COUNT_W-1:0] underflow_count;
   logic [COUNT_W-1:0] valid_count;
   logic [SUM_W-1:0]   value_sum;
   logic [VALUE_W-1:0] max_value;
   logic [COL_W-1:0]   max_col;
   logic [ROW_W-1:0]   max_row;
   logic [VALUE_W-1:0] min_value;
   logic [BYTES_W-1:0] byte_count;
   modport source (output valid, output out_byte, output pixel_done, output too_random,
                   output overflow_count, output underflow_count, output valid_count,
                   output value_sum, output max_value, output max_col, output max_row,
                   output min_value, output byte_count, input ready);
   modport sink (input valid, input out_byte, input pixel_done, input too_random,
                 input overflow_count, input underflow_count, input valid_count,
                 input value_sum, input max_value, input max_col, input max_row,
                 input min_value, input byte_count, output ready);
endinterface

interface bopc_csr_if;
   import bopc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bopc_front.sv =====
module bopc_front
   import bopc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   bopc_req_if.sink         req_chan,
   bopc_csr_if.sink         csr_chan,
   input  queue_status_type queue_status,
   output logic             push,
   output record_type       push_record
);

   logic [1:0]             sample_bits_ff;
   logic                   signed_ff;
   logic                   stats_off_ff;
   logic [ROW_WIDTH_W-1:0] row_width_ff;
   logic [COUNT_W-1:0]     pixel_count_ff;

   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic                seen_ff;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COUNT_W-1:0]  esc_ff, esc_in;
   stats_type           stats_ff, stats_in;

   logic [SAMPLE_W-1:0]    mask, half, sign_bit, v_raw, v, diff, mag;
   logic                   ovf, unf, start;
   logic [SAMPLE_W-1:0]    base_prev;
   logic                   base_seen;
   logic [COL_W-1:0]       base_col;
   logic [ROW_W-1:0]       base_row;
   logic [COUNT_W-1:0]     base_esc;
   stats_type              base;
   len_type                len;
   logic [SUM_W:0]         sum_wide;
   logic [ROW_WIDTH_W-1:0] width_eff, col_plus;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !queue_status.full;
   assign push           = req_chan.valid && !queue_status.full;
   assign start          = req_chan.image_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_bits_ff <= SAMPLE_32;
         signed_ff      <= 1'b1;
         stats_off_ff   <= 1'b0;
         row_width_ff   <= 15'd1024;
         pixel_count_ff <= 25'd1048576;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SAMPLE_BITS: sample_bits_ff <= csr_chan.data[1:0];
            CSR_SIGNED:      signed_ff      <= csr_chan.data[0];
            CSR_STATS_OFF:   stats_off_ff   <= csr_chan.data[0];
            CSR_ROW_WIDTH:   row_width_ff   <= csr_chan.data[ROW_WIDTH_W-1:0];
            CSR_PIXEL_COUNT: pixel_count_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Sample decode: cut to width, detect full scale and underflow, sign extend signed samples.
   always_comb begin
      case (sample_bits_ff)
         SAMPLE_8:  mask = 32'h0000_00FF;
         SAMPLE_16: mask = 32'h0000_FFFF;
         default:   mask = 32'hFFFF_FFFF;
      endcase
      half     = mask >> 1;
      sign_bit = half + 32'd1;
      v_raw    = req_chan.raw_sample & mask;
      if (signed_ff) begin
         ovf = (v_raw == half);
         unf = (v_raw == sign_bit);
         v   = ((v_raw & sign_bit) != '0) ? (v_raw | ~mask) : v_raw;
      end else begin
         ovf = (v_raw == mask);
         unf = (v_raw == '0);
         v   = v_raw;
      end
   end

   always_comb begin
      base_prev = start ? '0 : prev_ff;
      base_seen = start ? 1'b0 : seen_ff;
      base_col  = start ? '0 : col_ff;
      base_row  = start ? '0 : row_ff;
      base_esc  = start ? '0 : esc_ff;
      if (start) begin
         base           = '0;
         base.min_value = '1;
      end else begin
         base = stats_ff;
      end

      diff = v - base_prev;
      mag  = diff[SAMPLE_W-1] ? (32'd0 - diff) : diff;
      if (mag <= ONE_BYTE_LIMIT) begin
         len = LEN_ONE;
      end else if (mag <= TWO_BYTE_LIMIT) begin
         len = LEN_THREE;
      end else begin
         len = LEN_SEVEN;
      end

      prev_in  = v;
      stats_in = base;
      esc_in   = base_esc;
      if (len == LEN_SEVEN) begin
         esc_in = sat_inc_count(base_esc);
         if (esc_in > {2'b00, pixel_count_ff[COUNT_W-1:2]}) begin
            stats_in.too_random = 1'b1;
         end
      end
      if (ovf) begin
         stats_in.overflow_count = sat_inc_count(base.overflow_count);
      end
      if (unf) begin
         stats_in.underflow_count = sat_inc_count(base.underflow_count);
      end

      sum_wide = {1'b0, base.value_sum} + {{(SUM_W + 1 - VALUE_W){1'b0}}, v[VALUE_W-1:0]};
      if (!v[SAMPLE_W-1] && !stats_off_ff) begin
         stats_in.valid_count = sat_inc_count(base.valid_count);
         stats_in.value_sum   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
         if (v[VALUE_W-1:0] > base.max_value) begin
            stats_in.max_value = v[VALUE_W-1:0];
            stats_in.max_col   = base_col;
            stats_in.max_row   = base_row;
         end
         if ((v[VALUE_W-1:0] < base.min_value) || !base_seen) begin
            stats_in.min_value = v[VALUE_W-1:0];
         end
      end

      // Position advance; row width is clamped to 1..2^COL_W.
      if (row_width_ff == '0) begin
         width_eff = 15'd1;
      end else if (row_width_ff > MAX_ROW_WIDTH) begin
         width_eff = MAX_ROW_WIDTH;
      end else begin
         width_eff = row_width_ff;
      end
      col_plus = {1'b0, base_col} + 15'd1;
      if (col_plus >= width_eff) begin
         col_in = '0;
         row_in = (base_row == '1) ? base_row : base_row + 1'b1;
      end else begin
         col_in = col_plus[COL_W-1:0];
         row_in = base_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         seen_ff  <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
         esc_ff   <= '0;
         stats_ff <= STATS_CLEAR;
      end else if (push) begin
         prev_ff  <= prev_in;
         seen_ff  <= 1'b1;
         col_ff   <= col_in;
         row_ff   <= row_in;
         esc_ff   <= esc_in;
         stats_ff <= stats_in;
      end
   end

   always_comb begin
      push_record.diff        = diff;
      push_record.len         = len;
      push_record.image_start = start;
      push_record.stats       = stats_in;
   end

endmodule

// ===== hdl/bopc_queue.sv =====
module bopc_queue
   import bopc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  record_type       push_record,
   input  logic             pop,
   output record_type       head,
   output queue_status_type status
);

   record_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_record;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/bopc_back.sv =====
module bopc_back
   import bopc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  record_type       head,
   input  queue_status_type queue_status,
   output logic             pop,
   bopc_rsp_if.source       rsp_chan
);

   logic               valid_ff, valid_in;
   logic [2:0]         idx_ff, idx_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in, bytes_base;
   logic [7:0]         byte_ff, byte_sel;
   logic               done_ff;
   stats_type          stats_ff;
   logic [2:0]         last_idx;
   logic               is_last, load;

   always_comb begin
      case (head.len)
         LEN_ONE:   last_idx = 3'd0;
         LEN_THREE: last_idx = 3'd2;
         default:   last_idx = 3'd6;
      endcase
      is_last = (idx_ff == last_idx);
   end

   // Byte order of each code: escape markers first, then the difference LSB first.
   always_comb begin
      byte_sel = head.diff[7:0];
      if (head.len == LEN_THREE) begin
         case (idx_ff)
            3'd0:    byte_sel = ESCAPE_BYTE;
            3'd1:    byte_sel = head.diff[7:0];
            default: byte_sel = head.diff[15:8];
         endcase
      end else if (head.len == LEN_SEVEN) begin
         case (idx_ff)
            3'd0:    byte_sel = ESCAPE_BYTE;
            3'd1:    byte_sel = ZERO_BYTE;
            3'd2:    byte_sel = ESCAPE_BYTE;
            3'd3:    byte_sel = head.diff[7:0];
            3'd4:    byte_sel = head.diff[15:8];
            3'd5:    byte_sel = head.diff[23:16];
            default: byte_sel = head.diff[31:24];
         endcase
      end
   end

   assign load = !queue_status.empty && (!valid_ff || rsp_chan.ready);
   assign pop  = load && is_last;

   always_comb begin
      bytes_base = (head.image_start && idx_ff == '0) ? '0 : bytes_ff;
      bytes_in   = (bytes_base == '1) ? bytes_base : bytes_base + 1'b1;
      idx_in     = is_last ? 3'd0 : idx_ff + 3'd1;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
         bytes_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            idx_ff   <= idx_in;
            bytes_ff <= bytes_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= byte_sel;
         done_ff  <= is_last;
         stats_ff <= head.stats;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.out_byte        = byte_ff;
   assign rsp_chan.pixel_done      = done_ff;
   assign rsp_chan.too_random      = stats_ff.too_random;
   assign rsp_chan.overflow_count  = stats_ff.overflow_count;
   assign rsp_chan.underflow_count = stats_ff.underflow_count;
   assign rsp_chan.valid_count     = stats_ff.valid_count;
   assign rsp_chan.value_sum       = stats_ff.value_sum;
   assign rsp_chan.max_value       = stats_ff.max_value;
   assign rsp_chan.max_col         = stats_ff.max_col;
   assign rsp_chan.max_row         = stats_ff.max_row;
   assign rsp_chan.min_value       = stats_ff.min_value;
   assign rsp_chan.byte_count      = bytes_ff;

endmodule

// ===== hdl/byte_offset_pixel_compressor.sv =====
// Byte-offset pixel compressor with running image statistics.
// Pixels arrive on the req_chan channel, one request per pixel, with image_start
// set on the first pixel of an image to clear all running state. Compressed bytes
// leave on rsp_chan, one request per byte, with pixel_done on a pixel's last byte
// and the statistics after that pixel repeated on every byte of it.
// Configuration goes through csr_chan, which is always ready; write it only while
// the block is idle.
// An accepted pixel is written to the queue and then to the output register,
// from which its bytes leave on rsp_chan. A pixel whose difference fits one byte
// gives one byte, a 16-bit escape three and a 32-bit escape seven; the back-end
// serializer emits one byte per cycle while the receiver is ready and the queue
// holds a pixel. The front end classifies a pixel in the cycle it is accepted and
// places it in a four-entry queue, so it keeps taking pixels while the back end
// works through an escape or waits on a stalled receiver. When the queue fills,
// req_chan.ready drops; the output register holds the current byte on a stall.
// Reset empties the queue, drops rsp_chan.valid, clears all running state and
// loads the configuration defaults: 32-bit signed samples, statistics on, rows of
// 1024 pixels and images of 1048576 pixels.
module byte_offset_pixel_compressor
   import bopc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bopc_req_if.sink   req_chan,
   bopc_rsp_if.source rsp_chan,
   bopc_csr_if.sink   csr_chan
);

   logic             push, pop;
   record_type       push_record, head;
   queue_status_type queue_status;

   // Front end: decode, difference, classification and statistics.
   bopc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .csr_chan     (csr_chan),
      .queue_status (queue_status),
      .push         (push),
      .push_record  (push_record)
   );

   // Queue of classified pixels between the two halves.
   bopc_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_record (push_record),
      .pop         (pop),
      .head        (head),
      .status      (queue_status)
   );

   // Back end: byte serializer with the output register and byte counter.
   bopc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

endmodule

// ===== hdl/bopc_checker.sv =====
module bopc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_pixel_done,
   input logic        rsp_too_random,
   input logic [24:0] rsp_overflow_count,
   input logic [55:0] rsp_value_sum,
   input logic [30:0] rsp_min_value,
   input logic [26:0] rsp_byte_count
);

   logic mid_pixel;
   assign mid_pixel = rsp_valid && rsp_ready && !rsp_pixel_done;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_count))
      else $error("stalled result changed");

   a_pixel_continues: assert property (@(posedge clock) disable iff (reset)
      mid_pixel |=> rsp_valid)
      else $error("gap inside a pixel's bytes");

   a_pixel_stats_stable: assert property (@(posedge clock) disable iff (reset)
      mid_pixel |=> $stable(rsp_too_random) && $stable(rsp_overflow_count)
         && $stable(rsp_value_sum) && $stable(rsp_min_value))
      else $error("statistics changed inside a pixel");

   a_byte_count_step: assert property (@(posedge clock) disable iff (reset)
      mid_pixel |=> (rsp_byte_count == $past(rsp_byte_count) + 27'd1)
         || ($past(rsp_byte_count) == 27'h7FF_FFFF))
      else $error("byte count did not advance by one");

endmodule

bind byte_offset_pixel_compressor bopc_checker u_bopc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_out_byte       (rsp_chan.out_byte),
   .rsp_pixel_done     (rsp_chan.pixel_done),
   .rsp_too_random     (rsp_chan.too_random),
   .rsp_overflow_count (rsp_chan.overflow_count),
   .rsp_value_sum      (rsp_chan.value_sum),
   .rsp_min_value      (rsp_chan.min_value),
   .rsp_byte_count     (rsp_chan.byte_count)
);
